>>> rtl/sdt_pkg.sv
`default_nettype none
package sdt_pkg;

   localparam int FRAME_WIDTH  = 128;
   localparam int FRAME_HEIGHT = 128;

   localparam int COL_W = $clog2(FRAME_WIDTH);
   localparam int ROW_W = $clog2(FRAME_HEIGHT);

   localparam int PIX_W    = 8;
   localparam int THR_W    = 11;
   localparam int THR_SQ_W = 2 * THR_W;
   // |g| <= 4 * (2**PIX_W - 1), plus a sign bit
   localparam int GRAD_W   = PIX_W + 3;
   localparam int SQ_W     = 2 * (PIX_W + 2);
   localparam int MAG_W    = SQ_W + 1;

   localparam int STRONG_RESET = 100;
   localparam int WEAK_RESET   = 30;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRONG = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEAK   = 1'd1;

   localparam int CLASS_W = 2;
   localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_WEAK   = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_STRONG = 2'd2;

   // one request as it travels down the pipeline
   typedef struct packed {
      logic             valid;
      logic [COL_W-1:0] col;
      logic             is_class;
      logic             is_res;
      logic             last;
   } item_type;

   typedef struct packed {
      logic valid;
      logic edge_res;
      logic last;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/sdt_ram.sv
`default_nettype none
module sdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> rtl/sdt_pix.sv
`default_nettype none
module sdt_pix
   import sdt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire item_type         in_item,
   input  wire logic [PIX_W-1:0] in_pixel,
   output      item_type         out_item,
   output      logic [SQ_W-1:0]  out_gx_sq,
   output      logic [SQ_W-1:0]  out_gy_sq
);

   item_type         s1_item_ff, s2_item_ff, s3_item_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   logic [SQ_W-1:0]  gx_sq_ff, gy_sq_ff;

   // line entry: upper byte is the row above, lower byte two rows above
   logic [2*PIX_W-1:0] line_rd;
   logic [2*PIX_W-1:0] line_wr;
   logic               line_we;

   logic [PIX_W-1:0] win_ff [3][3];

   logic [GRAD_W-1:0]          w [3][3];
   logic [GRAD_W-1:0]          gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0]   gx, gy;
   logic signed [2*GRAD_W-1:0] gx_prod, gy_prod;

   assign line_we = adv && s1_item_ff.valid;
   assign line_wr = {s1_pixel_ff, line_rd[2*PIX_W-1:PIX_W]};

   sdt_ram #(
      .WIDTH(2 * PIX_W),
      .DEPTH(FRAME_WIDTH)
   ) u_line (
      .clock(clock),
      .we   (line_we),
      .waddr(s1_item_ff.col),
      .wdata(line_wr),
      .re   (adv),
      .raddr(in_item.col),
      .rdata(line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff <= '0;
         s2_item_ff <= '0;
         s3_item_ff <= '0;
      end else if (adv) begin
         s1_item_ff <= in_item;
         s2_item_ff <= s1_item_ff;
         s3_item_ff <= s2_item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pixel_ff <= in_pixel;
         gx_sq_ff    <= gx_prod[SQ_W-1:0];
         gy_sq_ff    <= gy_prod[SQ_W-1:0];
      end
      // slide the window by one column
      if (line_we) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= line_rd[PIX_W-1:0];
         win_ff[1][2] <= line_rd[2*PIX_W-1:PIX_W];
         win_ff[2][2] <= s1_pixel_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int l = 0; l < 3; l++) begin
            w[k][l] = GRAD_W'(win_ff[k][l]);
         end
      end
      gx_pos = w[0][0] + (w[0][1] << 1) + w[0][2];
      gx_neg = w[2][0] + (w[2][1] << 1) + w[2][2];
      gy_pos = w[0][0] + (w[1][0] << 1) + w[2][0];
      gy_neg = w[0][2] + (w[1][2] << 1) + w[2][2];
      gx      = $signed(gx_pos - gx_neg);
      gy      = $signed(gy_pos - gy_neg);
      gx_prod = gx * gx;
      gy_prod = gy * gy;
   end

   assign out_item  = s3_item_ff;
   assign out_gx_sq = gx_sq_ff;
   assign out_gy_sq = gy_sq_ff;

endmodule
`default_nettype wire

>>> rtl/sdt_cls.sv
`default_nettype none
module sdt_cls
   import sdt_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire item_type            in_item,
   input  wire logic [SQ_W-1:0]     gx_sq,
   input  wire logic [SQ_W-1:0]     gy_sq,
   input  wire logic [THR_SQ_W-1:0] strong_sq,
   input  wire logic [THR_SQ_W-1:0] weak_sq,
   output      result_type          result
);

   item_type           s4_item_ff;
   logic [CLASS_W-1:0] s4_class_ff;

   logic [MAG_W-1:0]    mag;
   logic [THR_SQ_W-1:0] mag_ext;
   logic [CLASS_W-1:0]  cls;

   // line entry: upper bits class of the row above, lower bits two rows above
   logic [2*CLASS_W-1:0] line_rd;
   logic [2*CLASS_W-1:0] line_wr;
   logic                 line_we;
   logic [COL_W-1:0]     rd_addr, wr_addr;

   logic [CLASS_W-1:0] cwin_ff [3][3];
   logic [CLASS_W-1:0] cwin    [3][3];
   logic               any_strong;
   logic               edge_res;

   assign mag     = MAG_W'(gx_sq) + MAG_W'(gy_sq);
   assign mag_ext = THR_SQ_W'(mag);

   always_comb begin
      if (mag_ext > strong_sq) begin
         cls = CLASS_STRONG;
      end else if (mag_ext < weak_sq) begin
         cls = CLASS_NONE;
      end else begin
         cls = CLASS_WEAK;
      end
   end

   // class of pixel (r-1, c-1) lives at column c-1
   assign rd_addr = in_item.col - COL_W'(1);
   assign wr_addr = s4_item_ff.col - COL_W'(1);
   assign line_we = adv && s4_item_ff.valid && s4_item_ff.is_class;
   assign line_wr = {s4_class_ff, line_rd[2*CLASS_W-1:CLASS_W]};

   sdt_ram #(
      .WIDTH(2 * CLASS_W),
      .DEPTH(FRAME_WIDTH)
   ) u_line (
      .clock(clock),
      .we   (line_we),
      .waddr(wr_addr),
      .wdata(line_wr),
      .re   (adv),
      .raddr(rd_addr),
      .rdata(line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_item_ff <= '0;
      end else if (adv) begin
         s4_item_ff <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_class_ff <= cls;
      end
      if (line_we) begin
         cwin_ff <= cwin;
      end
   end

   // window as it stands after this column slides in
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cwin[k][0] = cwin_ff[k][1];
         cwin[k][1] = cwin_ff[k][2];
      end
      cwin[0][2] = line_rd[CLASS_W-1:0];
      cwin[1][2] = line_rd[2*CLASS_W-1:CLASS_W];
      cwin[2][2] = s4_class_ff;
   end

   always_comb begin
      any_strong = 1'b0;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 3; b++) begin
            if ((a != 1 || b != 1) && cwin[a][b] == CLASS_STRONG) begin
               any_strong = 1'b1;
            end
         end
      end
      case (cwin[1][1])
         CLASS_STRONG: edge_res = 1'b1;
         CLASS_NONE:   edge_res = 1'b0;
         default:      edge_res = any_strong;
      endcase
   end

   assign result.valid    = s4_item_ff.valid && s4_item_ff.is_res;
   assign result.edge_res = edge_res;
   assign result.last     = s4_item_ff.last;

endmodule
`default_nettype wire

>>> rtl/sobel_double_threshold_edge.sv
`default_nettype none
// channel   | direction | payload                        | handshake
// ----------+-----------+--------------------------------+----------------------
// req       | in        | req_pixel[7:0]                 | req_valid / req_stall
// rsp       | out       | rsp_edge_res, rsp_frame_last   | rsp_valid / rsp_stall
// csr       | in        | csr_index, csr_wdata[10:0]     | csr_we
//
// One pixel per clock while req_stall is low. Two line memories (pixels, then
// classes) are read in the stage before their read-modify-write stage, so the
// pipeline is five stages deep: s1 to s4, then the rsp_valid output register.
// Reset is synchronous and clears the pipeline valids and the frame position,
// and loads the default thresholds; the line memories need no clearing.
// req_stall rises only while a result waits at the output and the next result
// is right behind it; other requests keep flowing.
module sobel_double_threshold_edge
   import sdt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [PIX_W-1:0]     req_pixel,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_edge_res,
   output      logic                 rsp_frame_last,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [THR_W-1:0]     csr_wdata
);

   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [THR_SQ_W-1:0] strong_sq_ff, weak_sq_ff;
   logic [THR_SQ_W-1:0] wr_sq;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_edge_ff, rsp_last_ff;

   logic       adv;
   logic       accept;
   logic       load;
   item_type   in_item;
   item_type   s3_item;
   logic [SQ_W-1:0] gx_sq, gy_sq;
   result_type result;

   // hold everything only when a result meets a full, stalled output
   assign adv       = !(rsp_valid_ff && rsp_stall && result.valid);
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign load      = adv && result.valid;

   assign in_item.valid    = accept;
   assign in_item.col      = col_ff;
   assign in_item.is_class = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign in_item.is_res   = (row_ff >= ROW_W'(4)) && (col_ff >= COL_W'(4));
   assign in_item.last     = (row_ff == ROW_W'(FRAME_HEIGHT - 1))
                          && (col_ff == COL_W'(FRAME_WIDTH - 1));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_ff == COL_W'(FRAME_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff == ROW_W'(FRAME_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // thresholds are kept squared
   assign wr_sq = THR_SQ_W'(csr_wdata) * THR_SQ_W'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         strong_sq_ff <= THR_SQ_W'(STRONG_RESET * STRONG_RESET);
         weak_sq_ff   <= THR_SQ_W'(WEAK_RESET * WEAK_RESET);
      end else if (csr_we) begin
         case (csr_index)
            CSR_STRONG: strong_sq_ff <= wr_sq;
            CSR_WEAK:   weak_sq_ff   <= wr_sq;
            default: ;
         endcase
      end
   end

   sdt_pix u_pix (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_item  (in_item),
      .in_pixel (req_pixel),
      .out_item (s3_item),
      .out_gx_sq(gx_sq),
      .out_gy_sq(gy_sq)
   );

   sdt_cls u_cls (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_item  (s3_item),
      .gx_sq    (gx_sq),
      .gy_sq    (gy_sq),
      .strong_sq(strong_sq_ff),
      .weak_sq  (weak_sq_ff),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_edge_ff <= result.edge_res;
         rsp_last_ff <= result.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_res   = rsp_edge_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule
`default_nettype wire
